>>> rtl/core/modexp_pkg.sv
package modexp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_t;

  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;
  localparam int BASE_WIDTH = 63;

endpackage

>>> rtl/core/modexp_if.sv
interface modexp_in_if #(
  parameter int EXP_WIDTH = 63
);
  logic                                valid;
  logic                                ready;
  logic [modexp_pkg::BASE_WIDTH-1:0]   base_value;
  logic [EXP_WIDTH-1:0]                exponent;
  modport source (output valid, output base_value, output exponent, input ready);
  modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface modexp_out_if #(
  parameter int MOD_WIDTH = 32
);
  logic        valid;
  logic        ready;
  logic [31:0] power_mod;
  modport source (output valid, output power_mod, input ready);
  modport sink (input valid, input power_mod, output ready);
endinterface

>>> rtl/core/modexp_mulmod.sv
module modexp_mulmod #(
  parameter int MOD_WIDTH = 32,
  parameter int A_WIDTH = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [A_WIDTH-1:0]   a,
  input  logic [MOD_WIDTH-1:0] b,
  input  logic [MOD_WIDTH-1:0] m,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] p
);

  localparam int CW = $clog2(A_WIDTH + 1);

  logic                 busy;
  logic [CW-1:0]        count;
  logic [A_WIDTH-1:0]   a_reg;
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH+1:0] dbl;
  logic [MOD_WIDTH+1:0] dbl_red;
  logic [MOD_WIDTH+1:0] add;
  logic [MOD_WIDTH-1:0] acc_next;

  always_comb begin
    dbl = {2'b0, acc} << 1;
    dbl_red = (dbl >= {2'b0, m}) ? dbl - {2'b0, m} : dbl;
    add = dbl_red + (a_reg[A_WIDTH-1] ? {2'b0, b} : '0);
    if (add >= {2'b0, m}) begin
      add = add - {2'b0, m};
    end
    acc_next = add[MOD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(A_WIDTH);
        a_reg <= a;
        acc <= '0;
      end else if (busy) begin
        acc <= acc_next;
        a_reg <= a_reg << 1;
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign p = acc;

endmodule

>>> rtl/core/modular_exponentiation.sv
// Sequence: one modular product reduces the base, then the exponent is worked through:
// one square for each of the 63 exponent bits and one multiply per set bit.
// Zero exponent or zero modulus: the result is given without any modular product.
// Throughput: one item at a time; the next item is taken once the result is taken.
// Reset (rst, synchronous): modulus returns to 1000000007, control goes idle.
module modular_exponentiation #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 63
) (
  input  logic        clk,
  input  logic        rst,
  modexp_in_if.sink   in_ch,
  modexp_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int BW = modexp_pkg::BASE_WIDTH;
  localparam int EW = $clog2(EXP_WIDTH + 1);

  modexp_pkg::state_t state, state_next;

  logic [MOD_WIDTH-1:0] modulus;
  logic [MOD_WIDTH-1:0] m;
  logic [MOD_WIDTH-1:0] r;
  logic [MOD_WIDTH-1:0] b;
  logic [EXP_WIDTH-1:0] e;
  logic [BW-1:0]        base_in;
  logic [EW-1:0]        bits;
  logic                 mm_start;
  logic [BW-1:0]        mm_a;
  logic [MOD_WIDTH-1:0] mm_b;
  logic                 mm_done;
  logic [MOD_WIDTH-1:0] mm_p;
  logic                 launched;
  logic                 out_valid;
  logic [31:0]          out_data;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(modulus) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_WIDTH'(modexp_pkg::MODULUS_RESET);
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      modulus <= pwdata[MOD_WIDTH-1:0];
    end
  end

  modexp_mulmod #(.MOD_WIDTH(MOD_WIDTH), .A_WIDTH(BW)) u_mulmod (
    .clk(clk), .rst(rst), .start(mm_start), .a(mm_a), .b(mm_b), .m(m),
    .done(mm_done), .p(mm_p)
  );

  assign in_ch.ready = (state == modexp_pkg::ST_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.power_mod = out_data;

  always_comb begin
    state_next = state;
    unique case (state)
      modexp_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          if (in_ch.exponent == '0 || modulus == '0) begin
            state_next = modexp_pkg::ST_DONE;
          end else begin
            state_next = modexp_pkg::ST_REDUCE;
          end
        end
      end
      modexp_pkg::ST_REDUCE: begin
        if (mm_done) state_next = modexp_pkg::ST_MUL;
      end
      modexp_pkg::ST_MUL: begin
        if (!e[0] || mm_done) state_next = modexp_pkg::ST_SQR;
      end
      modexp_pkg::ST_SQR: begin
        if (mm_done) begin
          state_next = (bits == EW'(1)) ? modexp_pkg::ST_DONE : modexp_pkg::ST_MUL;
        end
      end
      modexp_pkg::ST_DONE: state_next = modexp_pkg::ST_IDLE;
      default: state_next = modexp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mm_start = 1'b0;
    mm_a = BW'(r);
    mm_b = b;
    unique case (state)
      modexp_pkg::ST_REDUCE: begin
        mm_start = !launched;
        mm_a = base_in;
        mm_b = MOD_WIDTH'(1);
      end
      modexp_pkg::ST_MUL: begin
        mm_start = !launched && e[0];
      end
      modexp_pkg::ST_SQR: begin
        mm_start = !launched;
        mm_a = BW'(b);
      end
      default: mm_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modexp_pkg::ST_IDLE;
      launched <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (mm_start) launched <= 1'b1;
      else if (mm_done || state != state_next) launched <= 1'b0;
      unique case (state)
        modexp_pkg::ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            base_in <= in_ch.base_value;
            e <= in_ch.exponent;
            m <= modulus;
            bits <= EW'(EXP_WIDTH);
            r <= (in_ch.exponent == '0) ? MOD_WIDTH'(1) : '0;
          end
        end
        modexp_pkg::ST_REDUCE: begin
          if (mm_done) begin
            b <= mm_p;
            r <= (m == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
          end
        end
        modexp_pkg::ST_MUL: begin
          if (mm_done) r <= mm_p;
        end
        modexp_pkg::ST_SQR: begin
          if (mm_done) begin
            b <= mm_p;
            e <= e >> 1;
            bits <= bits - 1'b1;
          end
        end
        modexp_pkg::ST_DONE: begin
          out_valid <= 1'b1;
          out_data <= 32'(r);
        end
        default: ;
      endcase
    end
  end

endmodule

>>> tb/modexp_checker.sv
module modexp_checker (
  input  logic        clk,
  input  logic        rst,
  modexp_in_if        in_ch,
  modexp_out_if       out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  localparam logic [1:0] ADDR_MODULUS = 2'd0;

  logic [31:0] modulus_shadow;
  logic [31:0] power_queue[$];

  function automatic logic [31:0] expected_power(logic [62:0] b, logic [62:0] e,
                                                 logic [31:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    if (e == 0) return 32'd1;
    if (m == 0) return 32'd0;
    sq = {1'b0, b} % {32'd0, m};
    acc = 64'd1;
    for (int i = 0; i < 63; i++) begin
      if (e[i]) acc = (acc * sq) % {32'd0, m};
      sq = (sq * sq) % {32'd0, m};
    end
    return acc[31:0];
  endfunction

  task automatic report(string what);
    $display("modexp_checker: mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    modulus_shadow = modexp_pkg::MODULUS_RESET;
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      modulus_shadow = modexp_pkg::MODULUS_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_MODULUS) begin
        modulus_shadow = pwdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        power_queue.push_back(expected_power(in_ch.base_value, in_ch.exponent,
                                             modulus_shadow));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (power_queue.size() == 0) begin
          report($sformatf("unexpected item power_mod=%0d", out_ch.power_mod));
        end else begin
          want = power_queue.pop_front();
          if (out_ch.power_mod !== want) begin
            report($sformatf("power_mod got %0d want %0d", out_ch.power_mod, want));
          end
        end
      end
    end
    pending = power_queue.size();
  end

endmodule

>>> tb/modular_exponentiation_tb.sv
module modular_exponentiation_tb;

  localparam logic [1:0] ADDR_MODULUS = 2'd0;
  localparam logic [62:0] FIELD_MAX = {63{1'b1}};

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          idle_pct;
  int          stall_pct;
  int          hold_cycles;

  modexp_in_if  #(.EXP_WIDTH(63)) in_ch ();
  modexp_out_if #(.MOD_WIDTH(32)) out_ch ();

  modular_exponentiation #(.MOD_WIDTH(32), .EXP_WIDTH(63)) u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  modexp_checker u_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #100000000;
    $display("modular_exponentiation_tb: FAIL");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(logic [62:0] b, logic [62:0] e);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.base_value = b;
    in_ch.exponent = e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_modulus(logic [31:0] value);
    drain();
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ADDR_MODULUS;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [62:0] rand_wide();
    return {$urandom, $urandom} & FIELD_MAX;
  endfunction

  function automatic logic [62:0] rand_base();
    case ($urandom_range(5))
      0: return '0;
      1: return FIELD_MAX;
      2: return 63'($urandom_range(20));
      3: return 63'($urandom);
      default: return rand_wide();
    endcase
  endfunction

  function automatic logic [62:0] rand_exponent();
    int w;
    logic [62:0] e;
    if ($urandom_range(19) == 0) return '0;
    w = ($urandom_range(3) == 0) ? $urandom_range(17, 63) : $urandom_range(1, 16);
    e = rand_wide() & (FIELD_MAX >> (63 - w));
    e[w-1] = 1'b1;
    return e;
  endfunction

  task automatic random_phase(int count, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      send_item(rand_base(), rand_exponent());
    end
  endtask

  initial begin
    logic [31:0] moduli[8];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_MODULUS;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.base_value = '0;
    in_ch.exponent = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item('0, '0);
    send_item(FIELD_MAX, '0);
    send_item('0, 63'd1);
    send_item(63'd2, 63'd10);
    send_item(63'd3, FIELD_MAX);
    send_item(FIELD_MAX, FIELD_MAX);
    send_item(63'd1000000007, 63'd5);
    send_item(63'd1000000008, 63'd1000000006);
    send_item(FIELD_MAX, 63'd1);
    send_item(63'h2AAAAAAAAAAAAAAA, 63'h5555555555555555);
    send_item(63'h5555555555555555, 63'h2AAAAAAAAAAAAAAA);

    write_modulus(32'd1);
    send_item(63'd5, '0);
    send_item(63'd5, 63'd3);
    write_modulus(32'd0);
    send_item(63'd7, '0);
    send_item(63'd7, 63'd9);
    write_modulus(32'hFFFFFFFF);
    send_item(FIELD_MAX, FIELD_MAX);
    send_item(63'hFFFFFFFE, 63'd2);
    send_item(63'd2, 63'd31);
    write_modulus(32'd2);
    send_item(63'd3, FIELD_MAX);
    send_item(63'd4, 63'd1);

    moduli = '{32'd13, 32'hFFFFFFFB, 32'd1000000007, 32'hFFFFFFFF,
               32'd2, $urandom, 32'($urandom_range(3, 1000)), 32'h80000000};
    for (int p = 0; p < 8; p++) begin
      write_modulus(moduli[p]);
      case (p % 4)
        0: random_phase(16, 0, 0);
        1: random_phase(16, 49, 0);
        2: random_phase(16, 0, 49);
        default: random_phase(16, 24, 24);
      endcase
      if (p == 2) begin
        hold_cycles = 20000;
        random_phase(4, 0, 0);
      end
      if (p == 5) begin
        drain();
        random_phase(3, 0, 0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("modular_exponentiation_tb: PASS");
    end else begin
      $display("modular_exponentiation_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/modexp_pkg.sv
rtl/core/modexp_if.sv
rtl/core/modexp_mulmod.sv
rtl/core/modular_exponentiation.sv
tb/modexp_checker.sv
tb/modular_exponentiation_tb.sv
